/* design/vft_pkg.sv */
// vft_pkg: register codes, alignment decode, stage payload types and saturation helpers
// shared by the viewport fit transform top level and its testbench
// no dependencies
package vft_pkg;

  // configuration register indexes
  localparam logic CFG_ALIGN_MODE = 1'b0;
  localparam logic CFG_FIT_MODE   = 1'b1;

  // align_mode codes
  localparam logic [3:0] ALIGN_NONE      = 4'd0;
  localparam logic [3:0] ALIGN_XMIN_YMIN = 4'd1;
  localparam logic [3:0] ALIGN_XMIN_YMID = 4'd2;
  localparam logic [3:0] ALIGN_XMIN_YMAX = 4'd3;
  localparam logic [3:0] ALIGN_XMID_YMIN = 4'd4;
  localparam logic [3:0] ALIGN_XMID_YMID = 4'd5;
  localparam logic [3:0] ALIGN_XMID_YMAX = 4'd6;
  localparam logic [3:0] ALIGN_XMAX_YMIN = 4'd7;
  localparam logic [3:0] ALIGN_XMAX_YMID = 4'd8;
  localparam logic [3:0] ALIGN_XMAX_YMAX = 4'd9;
  // unused align codes, behave as none
  localparam logic [3:0] ALIGN_SPARE_LO  = 4'd10;
  localparam logic [3:0] ALIGN_SPARE_HI  = 4'd15;

  // fit_mode codes
  localparam logic [1:0] FIT_NONE  = 2'd0;
  localparam logic [1:0] FIT_MEET  = 2'd1;
  localparam logic [1:0] FIT_SLICE = 2'd2;
  localparam logic [1:0] FIT_SPARE = 2'd3;

  // slack position on one axis
  localparam logic [1:0] POS_MIN = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_MAX = 2'd2;

  localparam logic signed [66:0] WIDE_MAX = 67'sd2147483647;
  localparam logic signed [66:0] WIDE_MIN = -67'sd2147483648;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } sat_res_t;

  // geometry carried along the first half of the pipe
  typedef struct packed {
    logic signed [31:0] ol;
    logic signed [31:0] ot;
    logic signed [31:0] il;
    logic signed [31:0] it;
    logic signed [32:0] ow;
    logic signed [32:0] oh;
    logic signed [32:0] iw;
    logic signed [32:0] ih;
    logic               norm;
    logic               full;
  } geo_t;

  // plain results carried through the normalize divider
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic               sat;
    logic               nok;
    logic [3:0]         neg;
  } res_t;

  function automatic logic [1:0] pos_x(input logic [3:0] a);
    logic [1:0] p;
    unique case (a)
      ALIGN_XMIN_YMIN, ALIGN_XMIN_YMID, ALIGN_XMIN_YMAX: p = POS_MIN;
      ALIGN_XMID_YMIN, ALIGN_XMID_YMID, ALIGN_XMID_YMAX: p = POS_MID;
      ALIGN_XMAX_YMIN, ALIGN_XMAX_YMID, ALIGN_XMAX_YMAX: p = POS_MAX;
      default: p = POS_MIN;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] pos_y(input logic [3:0] a);
    logic [1:0] p;
    unique case (a)
      ALIGN_XMIN_YMIN, ALIGN_XMID_YMIN, ALIGN_XMAX_YMIN: p = POS_MIN;
      ALIGN_XMIN_YMID, ALIGN_XMID_YMID, ALIGN_XMAX_YMID: p = POS_MID;
      ALIGN_XMIN_YMAX, ALIGN_XMID_YMAX, ALIGN_XMAX_YMAX: p = POS_MAX;
      default: p = POS_MIN;
    endcase
    return p;
  endfunction

  // sign and clamp a quotient magnitude to 32 bits
  function automatic sat_res_t sat_mag(input logic [63:0] m, input logic neg);
    sat_res_t r;
    if (!neg && (m > 64'h0000_0000_7FFF_FFFF)) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (neg && (m > 64'h0000_0000_8000_0000)) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = neg ? -m[31:0] : m[31:0];
    end
    return r;
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic sat_res_t sat_wide(input logic signed [66:0] v);
    sat_res_t r;
    if (v > WIDE_MAX) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < WIDE_MIN) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/vft_div.sv */
// vft_div: multi-lane unsigned restoring divider, one quotient bit per register stage
// carries a side payload in step with the quotient; no package dependencies
module vft_div #(
  parameter int NW    = 49,
  parameter int DW    = 33,
  parameter int LANES = 2,
  parameter int PW    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [LANES-1:0][NW-1:0]     num_i,
  input  logic [LANES-1:0][DW-1:0]     den_i,
  input  logic [PW-1:0]                pay_i,
  output logic                         valid_o,
  output logic [LANES-1:0][NW-1:0]     quot_o,
  output logic [PW-1:0]                pay_o
);

  logic [NW-1:0]               v_q;
  logic [LANES-1:0][NW-1:0]    q_q [NW];
  logic [LANES-1:0][DW-1:0]    r_q [NW-1];
  logic [LANES-1:0][DW-1:0]    d_q [NW-1];
  logic [PW-1:0]               p_q [NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NW-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [LANES-1:0][NW-1:0] qin;
    logic [LANES-1:0][NW-1:0] qn;
    logic [LANES-1:0][DW-1:0] rin;
    logic [LANES-1:0][DW-1:0] din;
    logic [LANES-1:0][DW:0]   t;
    logic [LANES-1:0]         ge;
    logic [PW-1:0]            pin;

    if (s == 0) begin : g_first
      assign qin = num_i;
      assign rin = '0;
      assign din = den_i;
      assign pin = pay_i;
    end else begin : g_next
      assign qin = q_q[s-1];
      assign rin = r_q[s-1];
      assign din = d_q[s-1];
      assign pin = p_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign t[l]  = {rin[l], qin[l][NW-1]};
      assign ge[l] = t[l] >= {1'b0, din[l]};
      assign qn[l] = {qin[l][NW-2:0], ge[l]};
    end

    // partial remainder only matters before the last bit
    if (s < NW-1) begin : g_rem
      logic [LANES-1:0][DW:0]   df;
      logic [LANES-1:0][DW-1:0] rn;
      for (genvar l = 0; l < LANES; l++) begin : g_rl
        assign df[l] = t[l] - {1'b0, din[l]};
        assign rn[l] = ge[l] ? df[l][DW-1:0] : t[l][DW-1:0];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[s] <= rn;
          d_q[s] <= din;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[s] <= qn;
        p_q[s] <= pin;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quot_o  = q_q[NW-1];
  assign pay_o   = p_q[NW-1];

endmodule

/* design/viewport_fit_transform_unit.sv */
// viewport_fit_transform_unit: deep pipeline that fits an inner rectangle into an outer one
// depends on vft_pkg and on vft_div (two instances: fit divide and normalize divide)
//
// usage
//   input channel: in_valid_i / in_ready_o with the outer and inner rectangle edges (Q.FRAC_BITS)
//     and the normalize flag; a transaction is taken when both are high
//   output channel: out_valid_o / out_ready_i with scale, offset and the saturated flag
//   config channel: cfg_valid_i / cfg_ready_o, cfg_index_i picks align_mode or fit_mode,
//     cfg_data_i carries the value; always ready, write only while the pipe is empty
// throughput: one transaction per cycle, sustained while out_ready_i does not stall the pipe
// pipeline (Q16.16 at FRAC_BITS = 16): the input transaction reaches the result through
//   one size stage, 33 + FRAC_BITS fit-divide bit stages, six fit, offset and normalize-product stages,
//   64 normalize-divide bit stages and the output register
// stall: the whole pipe advances on one enable, so when the receiver holds out_ready_i low
//   with a result waiting, in_ready_o drops and every stage holds; bubbles travel as invalid
// reset: rst_ni clears all stage valid bits and loads align_mode = xmid ymid, fit_mode = meet
module viewport_fit_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] outer_left_i,
  input  logic signed [31:0] outer_top_i,
  input  logic signed [31:0] outer_right_i,
  input  logic signed [31:0] outer_bottom_i,
  input  logic signed [31:0] inner_left_i,
  input  logic signed [31:0] inner_top_i,
  input  logic signed [31:0] inner_right_i,
  input  logic signed [31:0] inner_bottom_i,
  input  logic               normalize_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] scale_x_o,
  output logic signed [31:0] scale_y_o,
  output logic signed [31:0] offset_x_o,
  output logic signed [31:0] offset_y_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [3:0]         cfg_data_i
);

  localparam int NW1 = 33 + FRAC_BITS;   // |outer size| << FRAC_BITS
  localparam int NW2 = 64;               // |inner size * scale| or |offset| << FRAC_BITS
  localparam int DW  = 33;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // global advance: whole pipe moves unless a finished result is stuck
  logic adv;

  logic [3:0] align_q;
  logic [1:0] fit_q;
  logic       aligned;

  // stage 1: sizes
  vft_pkg::geo_t p1_d, p1_q;
  logic          v1_q;

  // fit divider
  logic [32:0]               mow, moh;
  logic [1:0][NW1-1:0]       d1_num;
  logic [1:0][DW-1:0]        d1_den;
  logic [1:0][NW1-1:0]       d1_quot;
  vft_pkg::geo_t             d1_pay;
  logic                      d1_valid;

  // stage 2: signed, clamped axis scales
  vft_pkg::sat_res_t sat_x, sat_y;
  vft_pkg::geo_t     p2_q;
  logic              v2_q, sat2_q;
  logic signed [31:0] sx2_q, sy2_q;

  // stage 3: meet / slice pick
  logic signed [31:0] pick;
  vft_pkg::geo_t      p3_q;
  logic               v3_q, sat3_q;
  logic signed [31:0] sx3_q, sy3_q;

  // stage 4: products
  vft_pkg::geo_t      p4_q;
  logic               v4_q, sat4_q;
  logic signed [31:0] sx4_q, sy4_q;
  logic signed [63:0] px4_q, py4_q;
  logic signed [64:0] wx4_q, wy4_q;

  // stage 5: base offset and alignment slack
  logic signed [65:0] dx, dy, slx_d, sly_d;
  vft_pkg::geo_t      p5_q;
  logic               v5_q, sat5_q;
  logic signed [31:0] sx5_q, sy5_q;
  logic signed [65:0] tx5_q, ty5_q, slx5_q, sly5_q;

  // stage 6: clamped offsets, empty inner fallback
  vft_pkg::sat_res_t  rtx, rty;
  vft_pkg::geo_t      p6_q;
  logic               v6_q, sat6_d, sat6_q;
  logic signed [31:0] sx6_d, sy6_d, tx6_d, ty6_d;
  logic signed [31:0] sx6_q, sy6_q, tx6_q, ty6_q;

  // stage 7: normalize products
  logic               v7_q, sat7_q, nok7_q;
  logic signed [31:0] sx7_q, sy7_q, tx7_q, ty7_q;
  logic signed [32:0] ow7_q, oh7_q;
  logic signed [64:0] nx7_q, ny7_q;

  // normalize divider
  logic signed [64:0]  nxa, nya;
  logic [31:0]         mtx, mty;
  logic [3:0][NW2-1:0] d2_num;
  logic [3:0][DW-1:0]  d2_den;
  logic [3:0][NW2-1:0] d2_quot;
  vft_pkg::res_t       d2_pay_in, d2_pay;
  logic                d2_valid;

  // output register
  vft_pkg::sat_res_t  rn0, rn1, rn2, rn3;
  logic               out_valid_q, sat_out_q;
  logic signed [31:0] scale_x_q, scale_y_q, offset_x_q, offset_y_q;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= vft_pkg::ALIGN_XMID_YMID;
      fit_q   <= vft_pkg::FIT_MEET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vft_pkg::CFG_ALIGN_MODE: align_q <= cfg_data_i;
        vft_pkg::CFG_FIT_MODE:   fit_q   <= cfg_data_i[1:0];
      endcase
    end
  end

  // unused codes above the nine alignments act as none
  assign aligned = (align_q != vft_pkg::ALIGN_NONE) && (align_q <= vft_pkg::ALIGN_XMAX_YMAX);

  // ---------------- stage 1: sizes ----------------
  always_comb begin
    p1_d.ol   = outer_left_i;
    p1_d.ot   = outer_top_i;
    p1_d.il   = inner_left_i;
    p1_d.it   = inner_top_i;
    p1_d.ow   = $signed({outer_right_i[31], outer_right_i})
              - $signed({outer_left_i[31], outer_left_i});
    p1_d.oh   = $signed({outer_bottom_i[31], outer_bottom_i})
              - $signed({outer_top_i[31], outer_top_i});
    p1_d.iw   = $signed({inner_right_i[31], inner_right_i})
              - $signed({inner_left_i[31], inner_left_i});
    p1_d.ih   = $signed({inner_bottom_i[31], inner_bottom_i})
              - $signed({inner_top_i[31], inner_top_i});
    p1_d.norm = normalize_i;
    p1_d.full = !p1_d.iw[32] && (p1_d.iw != '0) && !p1_d.ih[32] && (p1_d.ih != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q <= p1_d;
    end
  end

  // ---------------- fit divide: outer / inner per axis ----------------
  assign mow       = p1_q.ow[32] ? -p1_q.ow : p1_q.ow;
  assign moh       = p1_q.oh[32] ? -p1_q.oh : p1_q.oh;
  assign d1_num[0] = {mow, {FRAC_BITS{1'b0}}};
  assign d1_num[1] = {moh, {FRAC_BITS{1'b0}}};
  assign d1_den[0] = p1_q.iw;
  assign d1_den[1] = p1_q.ih;

  vft_div #(
    .NW    (NW1),
    .DW    (DW),
    .LANES (2),
    .PW    ($bits(vft_pkg::geo_t))
  ) u_fit_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v1_q),
    .num_i   (d1_num),
    .den_i   (d1_den),
    .pay_i   (p1_q),
    .valid_o (d1_valid),
    .quot_o  (d1_quot),
    .pay_o   (d1_pay)
  );

  // ---------------- stage 2: sign and clamp ----------------
  assign sat_x = vft_pkg::sat_mag(64'(d1_quot[0]), d1_pay.ow[32]);
  assign sat_y = vft_pkg::sat_mag(64'(d1_quot[1]), d1_pay.oh[32]);

  // ---------------- stage 3: shared scale for meet / slice ----------------
  always_comb begin
    if (fit_q == vft_pkg::FIT_SLICE) begin
      pick = (sx2_q > sy2_q) ? sx2_q : sy2_q;
    end else begin
      pick = (sx2_q < sy2_q) ? sx2_q : sy2_q;
    end
  end

  // ---------------- stage 5: base offset and slack ----------------
  assign dx = 66'(p4_q.ow) - 66'(wx4_q >>> FRAC_BITS);
  assign dy = 66'(p4_q.oh) - 66'(wy4_q >>> FRAC_BITS);

  always_comb begin
    unique case (vft_pkg::pos_x(align_q))
      vft_pkg::POS_MID: slx_d = dx >>> 1;
      vft_pkg::POS_MAX: slx_d = dx;
      default:          slx_d = '0;
    endcase
    unique case (vft_pkg::pos_y(align_q))
      vft_pkg::POS_MID: sly_d = dy >>> 1;
      vft_pkg::POS_MAX: sly_d = dy;
      default:          sly_d = '0;
    endcase
    if (!aligned) begin
      slx_d = '0;
      sly_d = '0;
    end
  end

  // ---------------- stage 6: clamp offsets, empty inner fallback ----------------
  assign rtx = vft_pkg::sat_wide(67'(tx5_q) + 67'(slx5_q));
  assign rty = vft_pkg::sat_wide(67'(ty5_q) + 67'(sly5_q));

  always_comb begin
    if (p5_q.full) begin
      sx6_d  = sx5_q;
      sy6_d  = sy5_q;
      tx6_d  = rtx.val;
      ty6_d  = rty.val;
      sat6_d = sat5_q || rtx.sat || rty.sat;
    end else begin
      sx6_d  = ONE;
      sy6_d  = ONE;
      tx6_d  = p5_q.ol;
      ty6_d  = p5_q.ot;
      sat6_d = 1'b0;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (adv) begin
      v2_q <= d1_valid;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 2
      p2_q   <= d1_pay;
      sx2_q  <= sat_x.val;
      sy2_q  <= sat_y.val;
      sat2_q <= d1_pay.full && (sat_x.sat || sat_y.sat);
      // stage 3
      p3_q   <= p2_q;
      sat3_q <= sat2_q;
      sx3_q  <= aligned ? pick : sx2_q;
      sy3_q  <= aligned ? pick : sy2_q;
      // stage 4
      p4_q   <= p3_q;
      sat4_q <= sat3_q;
      sx4_q  <= sx3_q;
      sy4_q  <= sy3_q;
      px4_q  <= p3_q.il * sx3_q;
      py4_q  <= p3_q.it * sy3_q;
      wx4_q  <= p3_q.iw * sx3_q;
      wy4_q  <= p3_q.ih * sy3_q;
      // stage 5
      p5_q   <= p4_q;
      sat5_q <= sat4_q;
      sx5_q  <= sx4_q;
      sy5_q  <= sy4_q;
      tx5_q  <= 66'(p4_q.ol) - 66'(px4_q >>> FRAC_BITS);
      ty5_q  <= 66'(p4_q.ot) - 66'(py4_q >>> FRAC_BITS);
      slx5_q <= slx_d;
      sly5_q <= sly_d;
      // stage 6
      p6_q   <= p5_q;
      sx6_q  <= sx6_d;
      sy6_q  <= sy6_d;
      tx6_q  <= tx6_d;
      ty6_q  <= ty6_d;
      sat6_q <= sat6_d;
      // stage 7
      sx7_q  <= sx6_q;
      sy7_q  <= sy6_q;
      tx7_q  <= tx6_q;
      ty7_q  <= ty6_q;
      sat7_q <= sat6_q;
      ow7_q  <= p6_q.ow;
      oh7_q  <= p6_q.oh;
      nok7_q <= p6_q.norm && !p6_q.ow[32] && (p6_q.ow != '0)
                          && !p6_q.oh[32] && (p6_q.oh != '0);
      nx7_q  <= p6_q.iw * sx6_q;
      ny7_q  <= p6_q.ih * sy6_q;
    end
  end

  // ---------------- normalize divide: four lanes by outer size ----------------
  assign nxa = nx7_q[64] ? -nx7_q : nx7_q;
  assign nya = ny7_q[64] ? -ny7_q : ny7_q;
  assign mtx = tx7_q[31] ? -tx7_q : tx7_q;
  assign mty = ty7_q[31] ? -ty7_q : ty7_q;

  assign d2_num[0] = nxa[63:0];
  assign d2_num[1] = nya[63:0];
  assign d2_num[2] = {{(32-FRAC_BITS){1'b0}}, mtx, {FRAC_BITS{1'b0}}};
  assign d2_num[3] = {{(32-FRAC_BITS){1'b0}}, mty, {FRAC_BITS{1'b0}}};
  assign d2_den[0] = ow7_q;
  assign d2_den[1] = oh7_q;
  assign d2_den[2] = ow7_q;
  assign d2_den[3] = oh7_q;

  always_comb begin
    d2_pay_in.sx  = sx7_q;
    d2_pay_in.sy  = sy7_q;
    d2_pay_in.tx  = tx7_q;
    d2_pay_in.ty  = ty7_q;
    d2_pay_in.sat = sat7_q;
    d2_pay_in.nok = nok7_q;
    d2_pay_in.neg = {ty7_q[31], tx7_q[31], ny7_q[64], nx7_q[64]};
  end

  vft_div #(
    .NW    (NW2),
    .DW    (DW),
    .LANES (4),
    .PW    ($bits(vft_pkg::res_t))
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v7_q),
    .num_i   (d2_num),
    .den_i   (d2_den),
    .pay_i   (d2_pay_in),
    .valid_o (d2_valid),
    .quot_o  (d2_quot),
    .pay_o   (d2_pay)
  );

  // ---------------- output register ----------------
  assign rn0 = vft_pkg::sat_mag(d2_quot[0], d2_pay.neg[0]);
  assign rn1 = vft_pkg::sat_mag(d2_quot[1], d2_pay.neg[1]);
  assign rn2 = vft_pkg::sat_mag(d2_quot[2], d2_pay.neg[2]);
  assign rn3 = vft_pkg::sat_mag(d2_quot[3], d2_pay.neg[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (d2_pay.nok) begin
        scale_x_q  <= rn0.val;
        scale_y_q  <= rn1.val;
        offset_x_q <= rn2.val;
        offset_y_q <= rn3.val;
        sat_out_q  <= d2_pay.sat || rn0.sat || rn1.sat || rn2.sat || rn3.sat;
      end else begin
        scale_x_q  <= d2_pay.sx;
        scale_y_q  <= d2_pay.sy;
        offset_x_q <= d2_pay.tx;
        offset_y_q <= d2_pay.ty;
        sat_out_q  <= d2_pay.sat;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign scale_x_o   = scale_x_q;
  assign scale_y_o   = scale_y_q;
  assign offset_x_o  = offset_x_q;
  assign offset_y_o  = offset_y_q;
  assign saturated_o = sat_out_q;

`ifndef SYNTHESIS
  // a stalled receiver freezes every mid-pipe stage
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable({v2_q, v3_q, v4_q, v5_q, v6_q, v7_q}))
    else $error("pipe stage valids moved during output stall");

  // empty inner rectangle leaves unit scale and no clamp
  a_empty_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !p6_q.full) |-> ((sx6_q == ONE) && (sy6_q == ONE) && !sat6_q))
    else $error("empty inner rectangle did not give unit scale");

  // a new result only loads on an advancing cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("output register loaded while pipe was stalled");
`endif

endmodule

/* verif/tb_viewport_fit_transform_unit.sv */
// tb_viewport_fit_transform_unit: self-checking bench for the viewport fit transform unit
// depends on vft_pkg and viewport_fit_transform_unit; a queue-fed driver, a scoreboard
// monitor and an in-bench predictor of the fit, align and normalize arithmetic
module tb_viewport_fit_transform_unit;

  localparam int FRAC     = 16;
  localparam int LATENCY  = 105 + FRAC;
  localparam int SETTLE   = LATENCY + 20;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG = 5000;

  typedef struct {
    logic signed [31:0] ol, ot, orr, ob, il, it, ir, ib;
    logic               norm;
  } rect_pair_t;

  typedef struct {
    logic signed [31:0] sx, sy, tx, ty;
    logic               sat;
  } fit_xform_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] outer_left_i = '0, outer_top_i = '0, outer_right_i = '0;
  logic signed [31:0] outer_bottom_i = '0, inner_left_i = '0, inner_top_i = '0;
  logic signed [31:0] inner_right_i = '0, inner_bottom_i = '0;
  logic               normalize_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] scale_x_o, scale_y_o, offset_x_o, offset_y_o;
  logic               saturated_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = vft_pkg::CFG_ALIGN_MODE;
  logic [3:0]         cfg_data_i = '0;

  viewport_fit_transform_unit #(.FRAC_BITS(FRAC)) u_dut (.*);

  // clock: period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bench copy of the two registers, changed only while the pipe is empty
  logic [3:0] align_copy = vft_pkg::ALIGN_XMID_YMID;
  logic [1:0] fit_copy   = vft_pkg::FIT_MEET;

  rect_pair_t pending_rects[$];
  fit_xform_t expected_xforms[$];
  rect_pair_t on_bus;

  int  n_sent = 0, n_checked = 0, n_errors = 0, n_phases = 0;
  int  send_gap = 0, recv_gap = 0, hold_cnt = 0, idle_cycles = 0;
  bit  quiet = 1'b0;        // no random idling in the closing part of the run
  bit  hold_req = 1'b0;     // ask the receiver for one long stall
  bit  hold_done = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor: all intermediates kept wide, scales and finished offsets clamped at once
  // ---------------------------------------------------------------------------
  function automatic logic signed [127:0] clamp32(input logic signed [127:0] v,
                                                   inout bit sat);
    logic signed [127:0] hi, lo;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // alignment slack on one axis: nothing for min, floor half for mid, all for max
  function automatic logic signed [127:0] axis_slack(input logic signed [127:0] osz,
      input logic signed [127:0] isz, input logic signed [127:0] sc, input int pos);
    logic signed [127:0] d;
    if (pos == 0) return 0;
    d = osz - ((isz * sc) >>> FRAC);
    return (pos == 1) ? (d >>> 1) : d;
  endfunction

  function automatic fit_xform_t predict_fit(input rect_pair_t r, input logic [3:0] am,
                                             input logic [1:0] fm);
    logic signed [127:0] ow, oh, iw, ih, sx, sy, tx, ty, one, a, b;
    bit sat, aligned;
    int code;
    fit_xform_t x;
    sat = 1'b0;
    one = 128'sd1 <<< FRAC;
    a = r.orr; b = r.ol; ow = a - b;
    a = r.ob;  b = r.ot; oh = a - b;
    a = r.ir;  b = r.il; iw = a - b;
    a = r.ib;  b = r.it; ih = a - b;
    aligned = (am >= vft_pkg::ALIGN_XMIN_YMIN) && (am <= vft_pkg::ALIGN_XMAX_YMAX);
    if (iw > 0 && ih > 0) begin
      sx = clamp32((ow * one) / iw, sat);
      sy = clamp32((oh * one) / ih, sat);
      if (aligned) begin
        // slice takes the larger scale; meet, none and the spare code take the smaller
        if (fm == vft_pkg::FIT_SLICE) begin
          sx = (sx > sy) ? sx : sy;
        end else begin
          sx = (sx < sy) ? sx : sy;
        end
        sy = sx;
      end
      a = r.il; b = r.it;
      tx = r.ol - ((a * sx) >>> FRAC);
      ty = r.ot - ((b * sy) >>> FRAC);
      if (aligned) begin
        code = int'(am) - 1;
        tx = tx + axis_slack(ow, iw, sx, code / 3);
        ty = ty + axis_slack(oh, ih, sy, code % 3);
      end
      tx = clamp32(tx, sat);
      ty = clamp32(ty, sat);
    end else begin
      // empty inner rectangle: identity scale, outer origin
      sx = one;
      sy = one;
      tx = r.ol;
      ty = r.ot;
    end
    // normalize only for a positive outer size
    if (r.norm && ow > 0 && oh > 0) begin
      sx = clamp32((iw * sx) / ow, sat);
      sy = clamp32((ih * sy) / oh, sat);
      tx = clamp32((tx * one) / ow, sat);
      ty = clamp32((ty * one) / oh, sat);
    end
    x.sx = sx[31:0];
    x.sy = sy[31:0];
    x.tx = tx[31:0];
    x.ty = ty[31:0];
    x.sat = sat;
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents pending rectangle pairs, predicts on each accepted transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_xforms.push_back(predict_fit(on_bus, align_copy, fit_copy));
        n_sent <= n_sent + 1;
      end
      // a new transaction may only go out once the current one is taken
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap   <= $urandom_range(1, 12) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_rects.size() > 0) begin
          on_bus          = pending_rects.pop_front();
          outer_left_i   <= on_bus.ol;
          outer_top_i    <= on_bus.ot;
          outer_right_i  <= on_bus.orr;
          outer_bottom_i <= on_bus.ob;
          inner_left_i   <= on_bus.il;
          inner_top_i    <= on_bus.it;
          inner_right_i  <= on_bus.ir;
          inner_bottom_i <= on_bus.ib;
          normalize_i    <= on_bus.norm;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random backpressure plus one long stall, in-order scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    fit_xform_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_xforms.size() == 0) begin
          $display("%0t: result with nothing expected: sx %h sy %h tx %h ty %h sat %b",
                   $time, scale_x_o, scale_y_o, offset_x_o, offset_y_o, saturated_o);
          n_errors <= n_errors + 1;
        end else begin
          want = expected_xforms.pop_front();
          if (want.sx !== scale_x_o || want.sy !== scale_y_o || want.tx !== offset_x_o ||
              want.ty !== offset_y_o || want.sat !== saturated_o) begin
            $display("%0t: mismatch exp sx %h sy %h tx %h ty %h sat %b", $time,
                     want.sx, want.sy, want.tx, want.ty, want.sat);
            $display("%0t:          got sx %h sy %h tx %h ty %h sat %b", $time,
                     scale_x_o, scale_y_o, offset_x_o, offset_y_o, saturated_o);
            n_errors <= n_errors + 1;
          end
          n_checked <= n_checked + 1;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (hold_req && !hold_done && pending_rects.size() > 200) begin
        // start the long stall only while plenty of items are still being offered
        hold_cnt    <= LONG_HOLD;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap    <= $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_xforms.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic rect_pair_t make_rect(input logic signed [31:0] ol, ot, orr, ob,
                                           il, it, ir, ib, input logic norm);
    rect_pair_t r;
    r.ol = ol; r.ot = ot; r.orr = orr; r.ob = ob;
    r.il = il; r.it = it; r.ir = ir; r.ib = ib;
    r.norm = norm;
    return r;
  endfunction

  // a coordinate in a small window around zero, pixel scale in Q16.16
  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
  endfunction

  function automatic rect_pair_t random_rect();
    rect_pair_t r;
    int kind;
    kind = $urandom_range(0, 99);
    r.norm = 1'($urandom_range(0, 1));
    if (kind < 70) begin
      // well-formed pair: positive sizes, moderate magnitudes
      r.ol  = near_coord();
      r.ot  = near_coord();
      r.orr = r.ol + $urandom_range(1, 32'h0100_0000);
      r.ob  = r.ot + $urandom_range(1, 32'h0100_0000);
      r.il  = near_coord();
      r.it  = near_coord();
      r.ir  = r.il + $urandom_range(1, 32'h0100_0000);
      r.ib  = r.it + $urandom_range(1, 32'h0100_0000);
    end else if (kind < 80) begin
      // tiny inner size drives the scale into saturation
      r.ol  = $urandom;
      r.ot  = $urandom;
      r.orr = $urandom;
      r.ob  = $urandom;
      r.il  = near_coord();
      r.it  = near_coord();
      r.ir  = r.il + $urandom_range(1, 4);
      r.ib  = r.it + $urandom_range(1, 4);
    end else if (kind < 88) begin
      // empty or inverted inner, or inverted outer
      r.ol  = near_coord();
      r.ot  = near_coord();
      r.orr = near_coord();
      r.ob  = near_coord();
      r.il  = near_coord();
      r.it  = near_coord();
      r.ir  = ($urandom_range(0, 1) != 0) ? r.il : near_coord();
      r.ib  = near_coord();
    end else begin
      // raw noise over every bit
      r.ol = $urandom; r.ot = $urandom; r.orr = $urandom; r.ob = $urandom;
      r.il = $urandom; r.it = $urandom; r.ir = $urandom; r.ib = $urandom;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_rects.size() != 0 || in_valid_i || expected_xforms.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // both register writes back to back, then the channel goes idle
  task automatic write_regs(input logic [3:0] am, input logic [1:0] fm);
    @(posedge clk_i);
    cfg_index_i <= vft_pkg::CFG_ALIGN_MODE;
    cfg_data_i  <= am;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    align_copy = am;
    cfg_index_i <= vft_pkg::CFG_FIT_MODE;
    cfg_data_i  <= {2'b00, fm};
    do @(posedge clk_i); while (!cfg_ready_o);
    fit_copy = fm;
    cfg_valid_i <= 1'b0;
    n_phases++;
  endtask

  task automatic random_phase(input logic [3:0] am, input logic [1:0] fm, input int n);
    wait_drained();
    write_regs(am, fm);
    repeat (n) pending_rects.push_back(random_rect());
    while (pending_rects.size() != 0) @(posedge clk_i);
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE  = 32'sh0001_0000;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed corners under the reset settings (xmid ymid, meet)
    pending_rects.push_back(make_rect(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    pending_rects.push_back(make_rect(PMIN, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX, 1'b1));
    pending_rects.push_back(make_rect(PMAX, PMAX, PMIN, PMIN, PMAX, PMAX, PMIN, PMIN, 1'b0));
    pending_rects.push_back(make_rect(PMIN, PMIN, PMAX, PMAX, 0, 0, 1, 1, 1'b0));
    pending_rects.push_back(make_rect(PMAX, PMIN, PMIN, PMAX, 0, 0, 1, 1, 1'b1));
    // empty inner: zero width, then negative height
    pending_rects.push_back(make_rect(5 * ONE, 7 * ONE, 9 * ONE, 9 * ONE,
                                      ONE, ONE, ONE, 3 * ONE, 1'b1));
    pending_rects.push_back(make_rect(-3, -4, 100, 100, 0, 10, 5, 2, 1'b0));
    // plain fits, uneven aspect so mid slack has odd remainders
    pending_rects.push_back(make_rect(0, 0, 640 * ONE, 480 * ONE,
                                      0, 0, 100 * ONE, 30 * ONE, 1'b0));
    pending_rects.push_back(make_rect(ONE, 3, 641 * ONE + 1, 481 * ONE,
                                      -7 * ONE, 5, 93 * ONE, 31 * ONE + 3, 1'b1));
    // inverted outer gives negative scales; normalize is ignored there
    pending_rects.push_back(make_rect(100 * ONE, 100 * ONE, 0, 0,
                                      0, 0, 10 * ONE, 20 * ONE, 1'b1));
    // normalize with zero outer height
    pending_rects.push_back(make_rect(0, 4 * ONE, 50 * ONE, 4 * ONE,
                                      0, 0, 10 * ONE, 10 * ONE, 1'b1));
    // offset overflow from far inner origin
    pending_rects.push_back(make_rect(PMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN + 1, PMIN + 1,
                                      1'b0));
    pending_rects.push_back(make_rect(-1, -1, PMAX, PMAX, PMAX - 1, PMAX - 1, PMAX, PMAX,
                                      1'b1));
    while (pending_rects.size() != 0) @(posedge clk_i);

    // every named align code incl. stretch and both spare codes, every fit code incl. the spare
    random_phase(vft_pkg::ALIGN_NONE,      vft_pkg::FIT_NONE, 140);
    random_phase(vft_pkg::ALIGN_XMIN_YMIN, vft_pkg::FIT_SLICE, 130);
    random_phase(vft_pkg::ALIGN_XMIN_YMID, vft_pkg::FIT_NONE, 110);
    random_phase(vft_pkg::ALIGN_XMIN_YMAX, vft_pkg::FIT_SPARE, 110);
    random_phase(vft_pkg::ALIGN_XMID_YMIN, vft_pkg::FIT_SLICE, 110);

    // long receiver stall while the sender keeps offering: the pipe fills and stalls
    hold_req = 1'b1;
    random_phase(vft_pkg::ALIGN_XMID_YMAX, vft_pkg::FIT_MEET, 500);

    random_phase(vft_pkg::ALIGN_XMAX_YMIN, vft_pkg::FIT_SLICE, 110);
    random_phase(vft_pkg::ALIGN_XMAX_YMID, vft_pkg::FIT_MEET, 110);
    random_phase(vft_pkg::ALIGN_XMAX_YMAX, vft_pkg::FIT_SLICE, 110);
    random_phase(vft_pkg::ALIGN_SPARE_HI, vft_pkg::FIT_SLICE, 80);
    random_phase(vft_pkg::ALIGN_SPARE_LO, vft_pkg::FIT_SPARE, 60);
    random_phase(vft_pkg::ALIGN_XMID_YMID, vft_pkg::FIT_SLICE, 80);

    // closing part at full rate on both sides
    wait_drained();
    quiet = 1'b1;
    random_phase(vft_pkg::ALIGN_XMID_YMID, vft_pkg::FIT_MEET, 120);
    wait_drained();

    $display("covered %0d rectangle pairs over %0d register settings, %0d results checked",
             n_sent, n_phases, n_checked);
    $display("stretch, meet, slice, spare codes, empty and inverted rectangles, saturation");
    if (n_errors == 0 && expected_xforms.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
